>>> rtl/c8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_pkg
// Shared constants, opcodes, font table and controller/datapath types.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int STACK_DEPTH  = 16;
  localparam int PROGRAM_BASE = 512;
  localparam int FONT_BASE    = 80;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);

  localparam int MEM_DEPTH = 4096;
  localparam int MEM_AW    = 12;
  localparam int FB_ROWS   = 32;
  localparam int FB_AW     = 5;
  localparam int NUM_REGS  = 16;
  localparam int REG_AW    = 4;
  localparam int BCD_DIGITS = 3;

  localparam int GLYPH_N = 80;
  localparam logic [7:0] GLYPHS [GLYPH_N] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_ROW   = 2'd3;

  localparam logic [3:0] OP_SYS    = 4'h0;
  localparam logic [3:0] OP_JP     = 4'h1;
  localparam logic [3:0] OP_CALL   = 4'h2;
  localparam logic [3:0] OP_SE_I   = 4'h3;
  localparam logic [3:0] OP_SNE_I  = 4'h4;
  localparam logic [3:0] OP_SE_R   = 4'h5;
  localparam logic [3:0] OP_LD_I   = 4'h6;
  localparam logic [3:0] OP_ADD_I  = 4'h7;
  localparam logic [3:0] OP_ALU    = 4'h8;
  localparam logic [3:0] OP_SNE_R  = 4'h9;
  localparam logic [3:0] OP_LD_IDX = 4'hA;
  localparam logic [3:0] OP_JP_OFS = 4'hB;
  localparam logic [3:0] OP_RND    = 4'hC;
  localparam logic [3:0] OP_DRW    = 4'hD;
  localparam logic [3:0] OP_KEY    = 4'hE;
  localparam logic [3:0] OP_MISC   = 4'hF;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] F_GET_DT   = 8'h07;
  localparam logic [7:0] F_WAIT_KEY = 8'h0A;
  localparam logic [7:0] F_SET_DT   = 8'h15;
  localparam logic [7:0] F_SET_ST   = 8'h18;
  localparam logic [7:0] F_ADD_IDX  = 8'h1E;
  localparam logic [7:0] F_FONT     = 8'h29;
  localparam logic [7:0] F_BCD      = 8'h33;
  localparam logic [7:0] F_STORE    = 8'h55;
  localparam logic [7:0] F_LOAD     = 8'h65;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;
  localparam logic [11:0] PC_UNDERFLOW = 12'hFFF;
  localparam logic [3:0]  REG_VF = 4'hF;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_INIT,
    ACT_ACCEPT,
    ACT_CAPTURE,
    ACT_FETCH_HI,
    ACT_FETCH_LO,
    ACT_READ_Y,
    ACT_READ_V0,
    ACT_LATCH_V0,
    ACT_EXEC,
    ACT_FLAG,
    ACT_CLEAR,
    ACT_RETURN,
    ACT_BCD,
    ACT_STORE_RD,
    ACT_STORE_WR,
    ACT_LOAD_RD,
    ACT_LOAD_WR,
    ACT_DRAW_RD,
    ACT_DRAW_WR,
    ACT_RESULT
  } act_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] op;
    logic [3:0] n;
    logic [7:0] nn;
    logic       is_cls;
    logic       is_ret;
    logic       stack_empty;
    logic       init_last;
    logic       clear_last;
    logic       bcd_last;
    logic       block_last;
    logic       draw_last;
  } sts_t;

endpackage

>>> rtl/c8_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_if
// Handshake channels: instruction/access items in, results out, config write.
// ----------------------------------------------------------------------------
interface c8_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] mem_address;
  logic [7:0]  mem_data;
  logic [4:0]  row_select;
  logic [15:0] keys_down;
  logic [15:0] keys_released;
  logic [7:0]  random_byte;

  modport source (output valid, mode, mem_address, mem_data, row_select, keys_down,
                  keys_released, random_byte, input ready);
  modport sink (input valid, mode, mem_address, mem_data, row_select, keys_down,
                keys_released, random_byte, output ready);
endinterface

interface c8_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter_out;
  logic [15:0] index_out;
  logic [15:0] instruction_out;
  logic [7:0]  read_data;
  logic [63:0] display_row;
  logic        stack_error;
  logic        waiting_key;
  logic [7:0]  sound_timer_out;

  modport source (output valid, program_counter_out, index_out, instruction_out,
                  read_data, display_row, stack_error, waiting_key, sound_timer_out,
                  input ready);
  modport sink (input valid, program_counter_out, index_out, instruction_out,
                read_data, display_row, stack_error, waiting_key, sound_timer_out,
                output ready);
endinterface

interface c8_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/chip8_cpu_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_cpu_step
// CHIP-8 core executing one instruction or one memory/display access per item.
// ----------------------------------------------------------------------------
// After reset the core sweeps program memory (font image, zeros), the frame
// store and the data registers before it takes its first item; config writes
// are taken at any time. All storage sits in single-port-read RAMs, so the
// sequencer serializes access to them: a plain instruction runs two fetch
// reads, three register reads, execute and result hand-off. Flag-setting ops
// add a VF write, a return a stack pop, BCD a write per digit, 00E0 a write
// per frame row, a sprite draw a read and write per row plus the VF write, and
// FX55/FX65 a read and write per register. A finished result sits in an output
// register so the next item is accepted while it waits.
// ----------------------------------------------------------------------------
module chip8_cpu_step import c8_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  c8_in_if.sink     in_ch,
  c8_out_if.source  out_ch,
  c8_cfg_if.sink    cfg_ch
);

  act_t act;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  c8_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts,
    .act
  );

  c8_dp u_dp (
    .clk,
    .rst_n,
    .act,
    .sts,
    .in_mode             (in_ch.mode),
    .in_mem_address      (in_ch.mem_address),
    .in_mem_data         (in_ch.mem_data),
    .in_row_select       (in_ch.row_select),
    .in_keys_down        (in_ch.keys_down),
    .in_keys_released    (in_ch.keys_released),
    .in_random_byte      (in_ch.random_byte),
    .cfg_we              (cfg_ch.valid),
    .cfg_data            (cfg_ch.data),
    .out_program_counter (out_ch.program_counter_out),
    .out_index           (out_ch.index_out),
    .out_instruction     (out_ch.instruction_out),
    .out_read_data       (out_ch.read_data),
    .out_display_row     (out_ch.display_row),
    .out_stack_error     (out_ch.stack_error),
    .out_waiting_key     (out_ch.waiting_key),
    .out_sound_timer     (out_ch.sound_timer_out)
  );

endmodule

>>> rtl/c8_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/c8_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer: runs fetch, operand reads and execute, or an access, per item.
// ----------------------------------------------------------------------------
module c8_ctrl import c8_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output act_t act
);

  typedef enum logic [19:0] {
    ST_INIT     = 20'h00001,
    ST_IDLE     = 20'h00002,
    ST_CAPTURE  = 20'h00004,
    ST_FETCH_HI = 20'h00008,
    ST_FETCH_LO = 20'h00010,
    ST_READ_Y   = 20'h00020,
    ST_READ_V0  = 20'h00040,
    ST_LATCH_V0 = 20'h00080,
    ST_EXEC     = 20'h00100,
    ST_FLAG     = 20'h00200,
    ST_CLEAR    = 20'h00400,
    ST_RETURN   = 20'h00800,
    ST_BCD      = 20'h01000,
    ST_STORE_RD = 20'h02000,
    ST_STORE_WR = 20'h04000,
    ST_LOAD_RD  = 20'h08000,
    ST_LOAD_WR  = 20'h10000,
    ST_DRAW_RD  = 20'h20000,
    ST_DRAW_WR  = 20'h40000,
    ST_DONE     = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    act       = ACT_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        act = ACT_INIT;
        if (sts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act = ACT_ACCEPT;
          case (sts.mode)
            MODE_EXEC:  state_nxt = ST_FETCH_HI;
            MODE_WRITE: state_nxt = ST_DONE;
            default:    state_nxt = ST_CAPTURE;
          endcase
        end
      end
      ST_CAPTURE: begin
        act = ACT_CAPTURE;
        state_nxt = ST_DONE;
      end
      ST_FETCH_HI: begin
        act = ACT_FETCH_HI;
        state_nxt = ST_FETCH_LO;
      end
      ST_FETCH_LO: begin
        act = ACT_FETCH_LO;
        state_nxt = ST_READ_Y;
      end
      ST_READ_Y: begin
        act = ACT_READ_Y;
        state_nxt = ST_READ_V0;
      end
      ST_READ_V0: begin
        act = ACT_READ_V0;
        state_nxt = ST_LATCH_V0;
      end
      ST_LATCH_V0: begin
        act = ACT_LATCH_V0;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        act = ACT_EXEC;
        state_nxt = ST_DONE;
        case (sts.op)
          OP_SYS: begin
            if (sts.is_cls) state_nxt = ST_CLEAR;
            else if (sts.is_ret && !sts.stack_empty) state_nxt = ST_RETURN;
          end
          OP_ALU: begin
            if (sts.n inside {ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL}) begin
              state_nxt = ST_FLAG;
            end
          end
          OP_DRW: begin
            // zero-height sprite only clears VF
            state_nxt = (sts.n == 4'd0) ? ST_FLAG : ST_DRAW_RD;
          end
          OP_MISC: begin
            case (sts.nn)
              F_ADD_IDX: state_nxt = ST_FLAG;
              F_BCD:     state_nxt = ST_BCD;
              F_STORE:   state_nxt = ST_STORE_RD;
              F_LOAD:    state_nxt = ST_LOAD_RD;
              default:   state_nxt = ST_DONE;
            endcase
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_FLAG: begin
        act = ACT_FLAG;
        state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        act = ACT_CLEAR;
        if (sts.clear_last) state_nxt = ST_DONE;
      end
      ST_RETURN: begin
        act = ACT_RETURN;
        state_nxt = ST_DONE;
      end
      ST_BCD: begin
        act = ACT_BCD;
        if (sts.bcd_last) state_nxt = ST_DONE;
      end
      ST_STORE_RD: begin
        act = ACT_STORE_RD;
        state_nxt = ST_STORE_WR;
      end
      ST_STORE_WR: begin
        act = ACT_STORE_WR;
        state_nxt = sts.block_last ? ST_DONE : ST_STORE_RD;
      end
      ST_LOAD_RD: begin
        act = ACT_LOAD_RD;
        state_nxt = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        act = ACT_LOAD_WR;
        state_nxt = sts.block_last ? ST_DONE : ST_LOAD_RD;
      end
      ST_DRAW_RD: begin
        act = ACT_DRAW_RD;
        state_nxt = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        act = ACT_DRAW_WR;
        state_nxt = sts.draw_last ? ST_FLAG : ST_DRAW_RD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          act = ACT_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (act == ACT_RESULT) out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/c8_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_dp
// Datapath: memory, frame store, registers, stack, ALU and result register.
// ----------------------------------------------------------------------------
module c8_dp import c8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  act_t        act,
  output sts_t        sts,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_mem_address,
  input  logic [7:0]  in_mem_data,
  input  logic [4:0]  in_row_select,
  input  logic [15:0] in_keys_down,
  input  logic [15:0] in_keys_released,
  input  logic [7:0]  in_random_byte,
  input  logic        cfg_we,
  input  logic        cfg_data,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_index,
  output logic [15:0] out_instruction,
  output logic [7:0]  out_read_data,
  output logic [63:0] out_display_row,
  output logic        out_stack_error,
  output logic        out_waiting_key,
  output logic [7:0]  out_sound_timer
);

  // architectural state
  logic [11:0]     pc_r;
  logic [15:0]     idx_r;
  logic [SP_W-1:0] sp_r;
  logic [7:0]      dt_r, st_r;
  logic            quirk_r;
  logic [11:0]     cnt_r;

  // per-item working registers
  logic [1:0]  mode_r;
  logic [15:0] keysd_r, keysr_r;
  logic [7:0]  rnd_r;
  logic [15:0] ins_r;
  logic [7:0]  a_r, c_r, v0_r;
  logic        flag_r, serr_r, wait_r;
  logic [7:0]  rd_r;
  logic [63:0] row_r;

  // RAM ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              fb_we;
  logic [FB_AW-1:0]  fb_waddr, fb_raddr;
  logic [63:0]       fb_wdata, fb_rdata;
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr, rf_raddr;
  logic [7:0]        rf_wdata, rf_rdata;
  logic              sk_we;
  logic [SI_W-1:0]   sk_waddr, sk_raddr;
  logic [11:0]       sk_wdata, sk_rdata;

  c8_ram #(.W(8), .D(MEM_DEPTH)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
  c8_ram #(.W(64), .D(FB_ROWS)) u_fb (
    .clk, .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );
  c8_ram #(.W(8), .D(NUM_REGS)) u_rf (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );
  c8_ram #(.W(12), .D(STACK_DEPTH)) u_stk (
    .clk, .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  // instruction fields
  logic [3:0]  f_op, f_x, f_y, f_n;
  logic [7:0]  f_nn;
  logic [11:0] f_nnn;
  assign f_op  = ins_r[15:12];
  assign f_x   = ins_r[11:8];
  assign f_y   = ins_r[7:4];
  assign f_n   = ins_r[3:0];
  assign f_nn  = ins_r[7:0];
  assign f_nnn = ins_r[11:0];

  logic [11:0] idx_ofs;
  logic [5:0]  px;
  logic [4:0]  py, row_y;
  logic [5:0]  row_sum;
  assign idx_ofs = idx_r[11:0] + cnt_r;
  assign px      = a_r[5:0];
  assign py      = c_r[4:0];
  assign row_y   = py + cnt_r[4:0];
  assign row_sum = {1'b0, py} + {2'b00, cnt_r[3:0]};

  // font image for the reset sweep
  logic [11:0] font_ofs;
  logic        in_font;
  logic [7:0]  init_byte;
  assign font_ofs  = cnt_r - 12'(FONT_BASE);
  assign in_font   = ({1'b0, cnt_r} >= 13'(FONT_BASE)) &&
                     ({1'b0, cnt_r} < 13'(FONT_BASE + GLYPH_N));
  assign init_byte = in_font ? GLYPHS[font_ofs[6:0]] : 8'h00;

  // BCD digits: hundreds by compare, tens by reciprocal multiply
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic [7:0]  bcd_digit;
  always_comb begin
    if (a_r >= 8'd200)      bcd_h = 2'd2;
    else if (a_r >= 8'd100) bcd_h = 2'd1;
    else                    bcd_h = 2'd0;
    bcd_rem  = a_r - ({6'b0, bcd_h} * 8'd100);
    bcd_prod = {8'b0, bcd_rem[6:0]} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem - ({4'b0, bcd_t} * 8'd10);
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'b0, bcd_h};
      2'd1:    bcd_digit = {4'b0, bcd_t};
      default: bcd_digit = bcd_o;
    endcase
  end

  // sprite row
  logic [63:0] sprite;
  logic        collide;
  assign sprite  = {mem_rdata, 56'b0} >> px;
  assign collide = |(fb_rdata & sprite);

  // execute step
  logic [11:0]     ex_pc, pc_skip;
  logic [15:0]     ex_idx;
  logic [SP_W-1:0] ex_sp, sp_m1;
  logic [7:0]      ex_dt, ex_st, ex_val, sh_src;
  logic            ex_flag, ex_we, ex_serr, ex_wait, ex_push;
  logic [8:0]      sum9;
  logic [16:0]     sum_idx;
  logic            key_dn, key_found;
  logic [3:0]      key_idx;
  logic            stack_empty;

  assign pc_skip     = pc_r + 12'd2;
  assign sp_m1       = sp_r - 1'b1;
  assign sh_src      = quirk_r ? c_r : a_r;
  assign sum9        = {1'b0, a_r} + {1'b0, c_r};
  assign sum_idx     = {1'b0, idx_r} + {9'b0, a_r};
  assign key_dn      = (a_r[7:4] == 4'd0) && keysd_r[a_r[3:0]];
  assign stack_empty = (sp_r >= SP_W'(STACK_DEPTH));

  always_comb begin
    key_found = 1'b0;
    key_idx   = 4'd0;
    for (int k = NUM_REGS - 1; k >= 0; k--) begin
      if (keysr_r[k]) begin
        key_found = 1'b1;
        key_idx   = 4'(k);
      end
    end
  end

  always_comb begin
    ex_pc   = pc_r;
    ex_idx  = idx_r;
    ex_sp   = sp_r;
    ex_dt   = dt_r;
    ex_st   = st_r;
    ex_val  = 8'h00;
    ex_flag = 1'b0;
    ex_we   = 1'b0;
    ex_serr = 1'b0;
    ex_wait = 1'b0;
    ex_push = 1'b0;
    case (f_op)
      OP_SYS: begin
        if (ins_r == INS_RET && stack_empty) begin
          ex_serr = 1'b1;
          ex_pc   = PC_UNDERFLOW;
        end
      end
      OP_JP: ex_pc = f_nnn;
      OP_CALL: begin
        if (sp_r == '0) begin
          ex_serr = 1'b1;
        end else begin
          ex_sp   = sp_m1;
          ex_push = 1'b1;
        end
        ex_pc = f_nnn;
      end
      OP_SE_I:  if (a_r == f_nn) ex_pc = pc_skip;
      OP_SNE_I: if (a_r != f_nn) ex_pc = pc_skip;
      OP_SE_R:  if (a_r == c_r)  ex_pc = pc_skip;
      OP_SNE_R: if (a_r != c_r)  ex_pc = pc_skip;
      OP_LD_I: begin
        ex_we  = 1'b1;
        ex_val = f_nn;
      end
      OP_ADD_I: begin
        ex_we  = 1'b1;
        ex_val = a_r + f_nn;
      end
      OP_ALU: begin
        ex_we = 1'b1;
        case (f_n)
          ALU_MOV: ex_val = c_r;
          ALU_OR:  ex_val = a_r | c_r;
          ALU_AND: ex_val = a_r & c_r;
          ALU_XOR: ex_val = a_r ^ c_r;
          ALU_ADD: begin
            ex_val  = sum9[7:0];
            ex_flag = sum9[8];
          end
          ALU_SUB: begin
            ex_val  = a_r - c_r;
            ex_flag = (a_r >= c_r);
          end
          ALU_SHR: begin
            ex_val  = {1'b0, sh_src[7:1]};
            ex_flag = sh_src[0];
          end
          ALU_SUBN: begin
            ex_val  = c_r - a_r;
            ex_flag = (c_r >= a_r);
          end
          ALU_SHL: begin
            ex_val  = {sh_src[6:0], 1'b0};
            ex_flag = sh_src[7];
          end
          default: ex_we = 1'b0;
        endcase
      end
      OP_LD_IDX: ex_idx = {4'b0, f_nnn};
      OP_JP_OFS: ex_pc = f_nnn + {4'b0, (quirk_r ? v0_r : a_r)};
      OP_RND: begin
        ex_we  = 1'b1;
        ex_val = rnd_r & f_nn;
      end
      OP_KEY: begin
        if (f_nn == KEY_SKP && key_dn)       ex_pc = pc_skip;
        else if (f_nn == KEY_SKNP && !key_dn) ex_pc = pc_skip;
      end
      OP_MISC: begin
        case (f_nn)
          F_GET_DT: begin
            ex_we  = 1'b1;
            ex_val = dt_r;
          end
          F_WAIT_KEY: begin
            if (key_found) begin
              ex_we  = 1'b1;
              ex_val = {4'b0, key_idx};
            end else begin
              ex_pc   = pc_r - 12'd2;
              ex_wait = 1'b1;
            end
          end
          F_SET_DT: ex_dt = a_r;
          F_SET_ST: ex_st = a_r;
          F_ADD_IDX: begin
            ex_idx  = sum_idx[15:0];
            ex_flag = |sum_idx[16:12];
          end
          F_FONT: ex_idx = 16'(FONT_BASE) + {10'b0, a_r[3:0], 2'b00} + {12'b0, a_r[3:0]};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_ofs;
    mem_wdata = 8'h00;
    mem_raddr = idx_ofs;
    fb_we     = 1'b0;
    fb_waddr  = row_y;
    fb_wdata  = 64'h0;
    fb_raddr  = row_y;
    rf_we     = 1'b0;
    rf_waddr  = cnt_r[3:0];
    rf_wdata  = 8'h00;
    rf_raddr  = cnt_r[3:0];
    sk_we     = ex_push && (act == ACT_EXEC);
    sk_waddr  = sp_m1[SI_W-1:0];
    sk_wdata  = pc_r;
    sk_raddr  = sp_r[SI_W-1:0];
    case (act)
      ACT_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = init_byte;
        fb_we     = (cnt_r[11:5] == 7'd0);
        fb_waddr  = cnt_r[4:0];
        rf_we     = (cnt_r[11:4] == 8'd0);
        rf_waddr  = cnt_r[3:0];
      end
      ACT_ACCEPT: begin
        mem_we    = (in_mode == MODE_WRITE);
        mem_waddr = in_mem_address;
        mem_wdata = in_mem_data;
        mem_raddr = (in_mode == MODE_EXEC) ? pc_r : in_mem_address;
        fb_raddr  = in_row_select;
      end
      ACT_FETCH_HI: mem_raddr = pc_r + 12'd1;
      ACT_FETCH_LO: rf_raddr = f_x;
      ACT_READ_Y:   rf_raddr = f_y;
      ACT_READ_V0:  rf_raddr = 4'd0;
      ACT_EXEC: begin
        rf_we    = ex_we;
        rf_waddr = f_x;
        rf_wdata = ex_val;
      end
      ACT_FLAG: begin
        rf_we    = 1'b1;
        rf_waddr = REG_VF;
        rf_wdata = {7'b0, flag_r};
      end
      ACT_CLEAR: begin
        fb_we    = 1'b1;
        fb_waddr = cnt_r[4:0];
      end
      ACT_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit;
      end
      ACT_STORE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rf_rdata;
      end
      ACT_LOAD_WR: begin
        rf_we    = 1'b1;
        rf_wdata = mem_rdata;
      end
      ACT_DRAW_WR: begin
        fb_we    = 1'b1;
        fb_wdata = fb_rdata ^ sprite;
      end
      default: ;
    endcase
  end

  // status
  always_comb begin
    sts.mode        = in_mode;
    sts.op          = f_op;
    sts.n           = f_n;
    sts.nn          = f_nn;
    sts.is_cls      = (ins_r == INS_CLS);
    sts.is_ret      = (ins_r == INS_RET);
    sts.stack_empty = stack_empty;
    sts.init_last   = (cnt_r == 12'(MEM_DEPTH - 1));
    sts.clear_last  = (cnt_r[4:0] == 5'(FB_ROWS - 1));
    sts.bcd_last    = (cnt_r[1:0] == 2'(BCD_DIGITS - 1));
    sts.block_last  = (cnt_r[3:0] == f_x);
    sts.draw_last   = ((cnt_r[3:0] + 4'd1) == f_n) || (row_sum == 6'(FB_ROWS - 1));
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= 12'(PROGRAM_BASE);
      idx_r   <= 16'h0;
      sp_r    <= SP_W'(STACK_DEPTH);
      dt_r    <= 8'h00;
      st_r    <= 8'h00;
      quirk_r <= 1'b0;
      cnt_r   <= 12'h0;
    end else begin
      if (cfg_we) quirk_r <= cfg_data;
      case (act)
        ACT_INIT, ACT_CLEAR, ACT_BCD, ACT_DRAW_WR: cnt_r <= cnt_r + 12'd1;
        ACT_FETCH_LO: pc_r <= pc_skip;
        ACT_LATCH_V0: cnt_r <= 12'h0;
        ACT_EXEC: begin
          pc_r  <= ex_pc;
          idx_r <= ex_idx;
          sp_r  <= ex_sp;
          dt_r  <= ex_dt;
          st_r  <= ex_st;
        end
        ACT_RETURN: begin
          pc_r <= sk_rdata;
          sp_r <= sp_r + 1'b1;
        end
        ACT_STORE_WR, ACT_LOAD_WR: begin
          cnt_r <= cnt_r + 12'd1;
          if (sts.block_last && quirk_r) idx_r <= idx_r + {12'b0, f_x} + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    case (act)
      ACT_ACCEPT: begin
        mode_r  <= in_mode;
        keysd_r <= in_keys_down;
        keysr_r <= in_keys_released;
        rnd_r   <= in_random_byte;
        ins_r   <= 16'h0;
        rd_r    <= 8'h00;
        row_r   <= 64'h0;
        serr_r  <= 1'b0;
        wait_r  <= 1'b0;
      end
      ACT_CAPTURE: begin
        if (mode_r == MODE_READ) rd_r <= mem_rdata;
        else                     row_r <= fb_rdata;
      end
      ACT_FETCH_HI: ins_r[15:8] <= mem_rdata;
      ACT_FETCH_LO: ins_r[7:0] <= mem_rdata;
      ACT_READ_Y:   a_r <= rf_rdata;
      ACT_READ_V0:  c_r <= rf_rdata;
      ACT_LATCH_V0: begin
        v0_r   <= rf_rdata;
        flag_r <= 1'b0;
      end
      ACT_EXEC: begin
        flag_r <= ex_flag;
        serr_r <= ex_serr;
        wait_r <= ex_wait;
      end
      ACT_DRAW_WR: if (collide) flag_r <= 1'b1;
      ACT_RESULT: begin
        out_program_counter <= pc_r;
        out_index           <= idx_r;
        out_instruction     <= ins_r;
        out_read_data       <= rd_r;
        out_display_row     <= row_r;
        out_stack_error     <= serr_r;
        out_waiting_key     <= wait_r;
        out_sound_timer     <= st_r;
      end
      default: ;
    endcase
  end

endmodule
